// ===== hdl/air_to_ground_path_loss_defines.svh =====
// Assertion macros shared by the path loss RTL.
// Depends on nothing; expects clk and arst_n in the including scope.
`ifndef AIR_TO_GROUND_PATH_LOSS_DEFINES_SVH
`define AIR_TO_GROUND_PATH_LOSS_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define ATGPL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("atgpl assertion failed");

// Implication with a delay given by argument n, disabled in reset.
`define ATGPL_ASSERT_LAT(lbl, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("atgpl latency assertion failed");

`endif

// ===== hdl/atgpl_pkg.sv =====
// Constants, config register indexes and helper functions for the path loss block.
// Depends on nothing.
package atgpl_pkg;

	localparam int unsigned LOG_TABLE_DEPTH_DEF = 256;

	localparam logic [1:0] CFG_CARRIER = 2'd0;
	localparam logic [1:0] CFG_LOS     = 2'd1;

	localparam logic [16:0] CARRIER_RST = 17'd5180;

	localparam logic [18:0] LOG10_2_Q20 = 19'd315653;

	localparam int PL_MIN     = -2560;
	localparam int PL_MAX     = 102400;
	localparam int RX_MIN     = -153600;
	localparam int RX_MAX     = 28160;
	localparam int LOS_CONST  = -8192;
	localparam int NLOS_CONST = -11535;

	// Table entry: log2 of a Q30 mantissa by repeated squaring, Q16 result.
	function automatic logic [15:0] log_entry(logic [63:0] y0);
		logic [63:0] y;
		logic [15:0] r;
		y = y0;
		r = '0;
		for (int b = 15; b >= 0; b--) begin
			y = (y * y) >> 30;
			if (y >= (64'd2 << 30)) begin
				y = y >> 1;
				r[b] = 1'b1;
			end
		end
		return r;
	endfunction

	// Q16 log2 to Q16 log10, rounded.
	function automatic logic [20:0] to_log10(logic [21:0] v);
		logic [41:0] prod;
		prod = 42'(v) * 42'(LOG10_2_Q20) + (42'd1 << 19);
		return prod[40:20];
	endfunction

endpackage

// ===== hdl/air_to_ground_path_loss.sv =====
// Air-to-ground path loss: done marks the result of each start, one item per cycle.
// Fully pipelined, no stalls: busy is always low; the receiver cannot hold results.
// Throughput is one transaction per clock; the eleven stages set only the latency.
// arst_n clears valid bits and restores carrier 5180 MHz, line-of-sight mode.
// Depends on atgpl_pkg, atgpl_log2 and air_to_ground_path_loss_defines.svh.
`include "air_to_ground_path_loss_defines.svh"
module air_to_ground_path_loss #(
	parameter int unsigned LOG_TABLE_DEPTH = atgpl_pkg::LOG_TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [23:0] node_a_x,
	input  logic signed [23:0] node_a_y,
	input  logic signed [23:0] node_a_z,
	input  logic signed [23:0] node_b_x,
	input  logic signed [23:0] node_b_y,
	input  logic signed [23:0] node_b_z,
	input  logic signed [16:0] tx_power,
	output logic               done,
	output logic signed [17:0] path_loss,
	output logic signed [18:0] rx_power,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data
);
	localparam int NST  = 11;
	localparam int LGDW = $clog2(50) + 16;
	localparam int LGHW = $clog2(24) + 16;
	localparam int LGFW = $clog2(17) + 16;

	// configuration, taken at any time; the user must write it only while idle, the block does not enforce this
	logic [16:0] carrier_q;
	logic        los_cfg_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_q <= atgpl_pkg::CARRIER_RST;
			los_cfg_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				atgpl_pkg::CFG_CARRIER: carrier_q <= cfg_data;
				atgpl_pkg::CFG_LOS:     los_cfg_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// valid bits travel with the data, one per stage
	logic [NST-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else         vld_q <= {vld_q[NST-2:0], start && !busy};
	end

	// transmit power and mode ride alongside to the final stages
	logic signed [16:0] tx_q  [1:10];
	logic               mode_q [1:9];
	always_ff @(posedge clk) begin
		tx_q[1]   <= tx_power;
		mode_q[1] <= los_cfg_q;
		for (int k = 2; k <= 10; k++)
			tx_q[k] <= tx_q[k-1];
		for (int k = 2; k <= 9; k++)
			mode_q[k] <= mode_q[k-1];
	end

	// stage 1: differences, higher node height, carrier
	logic signed [24:0] dx_s1, dy_s1, dz_s1;
	logic [23:0]        h_s1;
	logic [16:0]        mhz_s1;
	logic signed [23:0] hz_c;

	assign hz_c = (node_a_z > node_b_z) ? node_a_z : node_b_z;

	always_ff @(posedge clk) begin
		dx_s1  <= 25'(node_a_x) - 25'(node_b_x);
		dy_s1  <= 25'(node_a_y) - 25'(node_b_y);
		dz_s1  <= 25'(node_a_z) - 25'(node_b_z);
		h_s1   <= (hz_c < 24'sd16) ? 24'd16 : 24'(hz_c);
		mhz_s1 <= (carrier_q == 17'd0) ? 17'd1 : carrier_q;
	end

	// stage 2: squares
	logic signed [49:0] px_c, py_c, pz_c;
	logic [47:0]        sx_s2, sy_s2, sz_s2;
	logic [23:0]        h_s2;
	logic [16:0]        mhz_s2;

	assign px_c = dx_s1 * dx_s1;
	assign py_c = dy_s1 * dy_s1;
	assign pz_c = dz_s1 * dz_s1;

	always_ff @(posedge clk) begin
		sx_s2  <= px_c[47:0];
		sy_s2  <= py_c[47:0];
		sz_s2  <= pz_c[47:0];
		h_s2   <= h_s1;
		mhz_s2 <= mhz_s1;
	end

	// stage 3: squared distance, raised to 1 m
	logic [49:0] d2_c, d2_s3;
	logic [23:0] h_s3;
	logic [16:0] mhz_s3;

	assign d2_c = 50'(sx_s2) + 50'(sy_s2) + 50'(sz_s2);

	always_ff @(posedge clk) begin
		d2_s3  <= (d2_c < 50'd256) ? 50'd256 : d2_c;
		h_s3   <= h_s2;
		mhz_s3 <= mhz_s2;
	end

	// stages 4 to 6: log2 of distance squared, height and carrier
	logic [LGDW-1:0] lgd_s6;
	logic [LGHW-1:0] lgh_s6;
	logic [LGFW-1:0] lgf_s6;

	atgpl_log2 #(.W(50), .DEPTH(LOG_TABLE_DEPTH)) u_log_d (
		.clk(clk), .x(d2_s3),  .lg(lgd_s6)
	);
	atgpl_log2 #(.W(24), .DEPTH(LOG_TABLE_DEPTH)) u_log_h (
		.clk(clk), .x(h_s3),   .lg(lgh_s6)
	);
	atgpl_log2 #(.W(17), .DEPTH(LOG_TABLE_DEPTH)) u_log_f (
		.clk(clk), .x(mhz_s3), .lg(lgf_s6)
	);

	// stage 7: remove the fixed-point scale and convert to log10
	logic [21:0] ld_c, lh_c;
	logic [20:0] l10d_s7, l10h_s7, l10f_s7;

	assign ld_c = 22'((lgd_s6 - LGDW'(8 * 65536)) >> 1);
	assign lh_c = 22'(lgh_s6 - LGHW'(4 * 65536));

	always_ff @(posedge clk) begin
		l10d_s7 <= atgpl_pkg::to_log10(ld_c);
		l10h_s7 <= atgpl_pkg::to_log10(lh_c);
		l10f_s7 <= atgpl_pkg::to_log10(22'(lgf_s6));
	end

	// stage 8: line-of-sight term, frequency term, height coefficient
	logic [25:0] t22_c, t20_c;
	logic [17:0] tlos_s8, tf_s8;
	logic [21:0] coef_s8;
	logic [20:0] l10d_s8;

	assign t22_c = 26'(l10d_s7) * 26'd22 + 26'd128;
	assign t20_c = 26'(l10f_s7) * 26'd20 + 26'd128;

	always_ff @(posedge clk) begin
		tlos_s8 <= t22_c[25:8];
		tf_s8   <= t20_c[25:8];
		coef_s8 <= 22'(23'(46 * 65536) - 23'(l10h_s7) * 23'd7);
		l10d_s8 <= l10d_s7;
	end

	// stage 9: height-dependent slope times log10 distance
	logic [42:0] p_s9;
	logic [17:0] tlos_s9, tf_s9;

	always_ff @(posedge clk) begin
		p_s9    <= 43'(coef_s8) * 43'(l10d_s8);
		tlos_s9 <= tlos_s8;
		tf_s9   <= tf_s8;
	end

	// stage 10: sum the terms and saturate the loss
	logic [43:0]        pr_c;
	logic signed [22:0] loss_c;
	logic signed [17:0] loss_s10;

	assign pr_c = 44'(p_s9) + (44'd1 << 23);

	// the mode bit sits beside the stage 9 terms it selects between
	always_comb begin
		if (mode_q[9])
			loss_c = 23'(atgpl_pkg::LOS_CONST) + 23'(tlos_s9) + 23'(tf_s9);
		else
			loss_c = 23'(atgpl_pkg::NLOS_CONST) + 23'(pr_c[43:24]) + 23'(tf_s9);
	end

	always_ff @(posedge clk) begin
		if (loss_c < 23'(atgpl_pkg::PL_MIN))      loss_s10 <= 18'(atgpl_pkg::PL_MIN);
		else if (loss_c > 23'(atgpl_pkg::PL_MAX)) loss_s10 <= 18'(atgpl_pkg::PL_MAX);
		else                                      loss_s10 <= loss_c[17:0];
	end

	// stage 11: received power, saturated; drive the result ports
	logic signed [19:0] rx_c;

	assign rx_c = 20'(tx_q[10]) - 20'(loss_s10);

	always_ff @(posedge clk) begin
		path_loss <= loss_s10;
		if (rx_c < 20'(atgpl_pkg::RX_MIN))      rx_power <= 19'(atgpl_pkg::RX_MIN);
		else if (rx_c > 20'(atgpl_pkg::RX_MAX)) rx_power <= 19'(atgpl_pkg::RX_MAX);
		else                                    rx_power <= rx_c[18:0];
	end

	assign done = vld_q[NST-1];

	// every accepted transaction raises done once it leaves the last stage
	`ATGPL_ASSERT_LAT(a_latency, start && !busy, 11, done)
	`ATGPL_ASSERT_IMP(a_no_spurious, !$past(start && !busy, 11), !done)
	`ATGPL_ASSERT_IMP(a_pl_range, done, (path_loss >= 18'(atgpl_pkg::PL_MIN)) && (path_loss <= 18'(atgpl_pkg::PL_MAX)))
	`ATGPL_ASSERT_IMP(a_rx_range, done, (rx_power >= 19'(atgpl_pkg::RX_MIN)) && (rx_power <= 19'(atgpl_pkg::RX_MAX)))

endmodule

// ===== hdl/atgpl_log2.sv =====
// Three-stage log2 unit: leading-one normalise, table index scale, table add.
// Depends on atgpl_pkg for the table entry function.
module atgpl_log2 #(
	parameter int unsigned W     = 50,
	parameter int unsigned DEPTH = atgpl_pkg::LOG_TABLE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic [W-1:0]              x,
	output logic [$clog2(W)+15:0]     lg
);
	localparam int EW = $clog2(W);
	localparam int IW = $clog2(DEPTH);
	localparam int DW = $clog2(DEPTH) + 1;
	localparam int LW = EW + 16;

	logic [15:0] tab [DEPTH];
	for (genvar g = 0; g < DEPTH; g++) begin : g_tab
		assign tab[g] = atgpl_pkg::log_entry(((64'(g) << 30) / DEPTH) + (64'd1 << 30));
	end

	logic [EW-1:0]   e_c;
	logic [W-1:0]    n_c;
	logic [W+30:0]   frac_c;
	logic [EW-1:0]   e_s1, e_s2;
	logic [31:0]     f_s1;
	logic [IW-1:0]   idx_s2;
	logic [32+DW-1:0] prod_c;

	// leading one and normalise so the top bit sits at W-1
	always_comb begin
		e_c = '0;
		for (int i = 0; i < W; i++) begin
			if (x[i]) e_c = EW'(i);
		end
		n_c    = x << (EW'(W - 1) - e_c);
		frac_c = {n_c[W-2:0], 32'd0};
	end

	assign prod_c = (32+DW)'(f_s1) * (32+DW)'(DEPTH);

	always_ff @(posedge clk) begin
		e_s1   <= e_c;
		f_s1   <= frac_c[W+30 -: 32];
		e_s2   <= e_s1;
		idx_s2 <= prod_c[32 +: IW];
		lg     <= LW'({e_s2, 16'd0}) + LW'(tab[idx_s2]);
	end

endmodule
